// ===== rtl/stq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
package stq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int HANDLE_W     = 4;
  localparam int HANDLE_SPACE = 1 << HANDLE_W;
  localparam int TIME_W       = 48;
  localparam int TAG_W        = 32;
  localparam int STATUS_W     = 3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_QUERY,
    OP_EXPIRE
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK,
    STS_FULL,
    STS_NOT_FOUND,
    STS_EMPTY,
    STS_EXPIRED,
    STS_NONE_DUE
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_PULL
  } cell_op_t;

  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] id;
  } entry_t;

  typedef struct packed {
    cell_op_t            op;
    logic [TIME_W-1:0]   now;
    logic [HANDLE_W-1:0] handle;
    entry_t              fresh;
  } cell_ctl_t;

  typedef struct packed {
    logic keep;
    logic due;
    logic hit;
  } cell_stat_t;

endpackage

// ===== rtl/stq_cell.sv =====
// One cell of the sorted chain: holds a timer entry and shifts with its neighbours.
module stq_cell import stq_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       valid,
  input  logic       take_right,
  input  logic       keep_left,
  input  entry_t     left_ent,
  input  entry_t     right_ent,
  output entry_t     ent,
  output cell_stat_t stat
);

  entry_t ent_r;
  entry_t ent_nxt;

  // keep: entry stays put on insert; due: expired at ctl.now; hit: handle match
  assign stat.keep = valid && (ent_r.deadline < ctl.now);
  assign stat.due  = valid && (ent_r.deadline <= ctl.now);
  assign stat.hit  = valid && (ent_r.id == ctl.handle);
  assign ent       = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      CELL_PUSH: begin
        if (!stat.keep) begin
          if (keep_left) begin
            ent_nxt = ctl.fresh;
          end else begin
            ent_nxt = left_ent;
          end
        end
      end
      CELL_PULL: begin
        if (take_right) begin
          ent_nxt = right_ent;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== rtl/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: command control, handle pool and the cell chain.
//
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------------------------
//  input    | start / busy      | in_operation, in_time_us, in_timer_tag, in_timer_handle
//  result   | out_valid strobe  | out_status, out_handle_out, out_tag_out,
//           |                   | out_deadline_out, out_delay_us, out_last_result
//
//  A command transfers when start is high and busy is low. It is worked against
//  the cell chain in S_EXEC and its result is then registered, for add, remove
//  and query alike. An expire run shows one result per cycle, one for each due
//  timer popped from the head cell, moving to S_DRAIN while the next cell is due.
//  Reset clears the state machine, the pending count and the handle pool; cell
//  contents are left as they are. The result side cannot stall: each result
//  stands on the ports for exactly one cycle.
module sorted_timer_queue import stq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [TIME_W-1:0]   in_time_us,
  input  logic [TAG_W-1:0]    in_timer_tag,
  input  logic [HANDLE_W-1:0] in_timer_handle,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [TAG_W-1:0]    out_tag_out,
  output logic [TIME_W-1:0]   out_deadline_out,
  output logic [TIME_W-1:0]   out_delay_us,
  output logic                out_last_result
);

  // Capacity is bounded both by the cells and by the 4-bit handle space
  localparam int CAPACITY = (DEPTH < HANDLE_SPACE) ? DEPTH : HANDLE_SPACE;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;

  // Command held for the whole of its work
  op_t                 op_r;
  logic [TIME_W-1:0]   time_r;
  logic [TAG_W-1:0]    tag_r;
  logic [HANDLE_W-1:0] handle_r;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [HANDLE_SPACE-1:0] busy_r, busy_nxt;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic [TIME_W-1:0]   out_deadline_r, out_deadline_nxt;
  logic [TIME_W-1:0]   out_delay_r, out_delay_nxt;
  logic                out_last_r, out_last_nxt;

  // Cell chain
  cell_ctl_t        ctl;
  entry_t           ent  [DEPTH];
  cell_stat_t       stat [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] keep_v;
  logic [DEPTH-1:0] due_v;
  logic [DEPTH-1:0] hit_v;
  logic [DEPTH-1:0] take_right;
  logic [DEPTH-1:0] rm_tail;

  // Handle pool
  logic [HANDLE_SPACE-1:0] cap_mask;
  logic [HANDLE_SPACE-1:0] free_v;
  logic [HANDLE_W-1:0]     new_h;
  logic                    any_free;

  assign busy = (state_r != S_IDLE);

  // Cells below the pending count hold live timers
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i]  = (CNT_W'(i) < count_r);
      keep_v[i] = stat[i].keep;
      due_v[i]  = stat[i].due;
      hit_v[i]  = stat[i].hit;
    end
  end

  // Cells from the matching one upwards pull from the right on a remove
  assign rm_tail = ~(hit_v - DEPTH'(1));

  // Lowest free handle within capacity
  always_comb begin
    for (int h = 0; h < HANDLE_SPACE; h++) begin
      cap_mask[h] = (h < CAPACITY);
    end
    free_v   = ~busy_r & cap_mask;
    any_free = |free_v;
    new_h    = '0;
    for (int h = HANDLE_SPACE - 1; h >= 0; h--) begin
      if (free_v[h]) begin
        new_h = HANDLE_W'(h);
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t left_ent;
      entry_t right_ent;
      logic   keep_left;
      if (gi == 0) begin : g_head
        assign left_ent  = ctl.fresh;
        assign keep_left = 1'b1;
      end else begin : g_body
        assign left_ent  = ent[gi-1];
        assign keep_left = keep_v[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
        assign right_ent = ent[gi];
      end else begin : g_inner
        assign right_ent = ent[gi+1];
      end
      stq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid      (valid[gi]),
        .take_right (take_right[gi]),
        .keep_left  (keep_left),
        .left_ent   (left_ent),
        .right_ent  (right_ent),
        .ent        (ent[gi]),
        .stat       (stat[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command and result payload need no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r     <= op_t'(in_operation);
      time_r   <= in_time_us;
      tag_r    <= in_timer_tag;
      handle_r <= in_timer_handle;
    end
    out_status_r   <= out_status_nxt;
    out_handle_r   <= out_handle_nxt;
    out_tag_r      <= out_tag_nxt;
    out_deadline_r <= out_deadline_nxt;
    out_delay_r    <= out_delay_nxt;
    out_last_r     <= out_last_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    busy_nxt         = busy_r;
    ctl.op           = CELL_HOLD;
    ctl.now          = time_r;
    ctl.handle       = handle_r;
    ctl.fresh.deadline = time_r;
    ctl.fresh.tag    = tag_r;
    ctl.fresh.id     = new_h;
    take_right       = '0;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = STS_OK;
    out_handle_nxt   = '0;
    out_tag_nxt      = '0;
    out_deadline_nxt = '0;
    out_delay_nxt    = '0;
    out_last_nxt     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC, S_DRAIN: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
        case (op_r)
          OP_ADD: begin
            if ((count_r >= CNT_W'(CAPACITY)) || !any_free) begin
              out_status_nxt = STS_FULL;
            end else begin
              // Insert ahead of equal deadlines, push the tail one cell right
              ctl.op           = CELL_PUSH;
              count_nxt        = count_r + CNT_W'(1);
              busy_nxt[new_h]  = 1'b1;
              out_status_nxt   = STS_OK;
              out_handle_nxt   = new_h;
            end
          end
          OP_REMOVE: begin
            out_handle_nxt = handle_r;
            if (!busy_r[handle_r]) begin
              out_status_nxt = STS_NOT_FOUND;
            end else begin
              // Close the gap: the matching cell and those above pull left
              ctl.op             = CELL_PULL;
              take_right         = rm_tail;
              count_nxt          = count_r - CNT_W'(|hit_v);
              busy_nxt[handle_r] = 1'b0;
              out_status_nxt     = STS_OK;
            end
          end
          OP_QUERY: begin
            if (count_r == '0) begin
              out_status_nxt = STS_EMPTY;
            end else begin
              out_status_nxt = STS_OK;
              out_delay_nxt  = due_v[0] ? '0 : (ent[0].deadline - time_r);
            end
          end
          OP_EXPIRE: begin
            if (due_v[0]) begin
              // Pop the head; carry on while the next cell is due as well
              ctl.op              = CELL_PULL;
              take_right          = '1;
              count_nxt           = count_r - CNT_W'(1);
              busy_nxt[ent[0].id] = 1'b0;
              out_status_nxt      = STS_EXPIRED;
              out_handle_nxt      = ent[0].id;
              out_tag_nxt         = ent[0].tag;
              out_deadline_nxt    = ent[0].deadline;
              out_last_nxt        = !due_v[1];
              state_nxt           = due_v[1] ? S_DRAIN : S_IDLE;
            end else begin
              out_status_nxt = STS_NONE_DUE;
            end
          end
          default: begin
            out_status_nxt = STS_NONE_DUE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_handle_out   = out_handle_r;
  assign out_tag_out      = out_tag_r;
  assign out_deadline_out = out_deadline_r;
  assign out_delay_us     = out_delay_r;
  assign out_last_result  = out_last_r;

endmodule

// ===== rtl/stq_checker.sv =====
// Port-level checks for the sorted timer queue, bound to the top level.
module stq_checker import stq_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_last_result
);

  // A transfer always starts work in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // Only the final result of a command releases busy
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy == !out_last_result))
    else $error("busy disagrees with last_result");

  // A result follows a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // An unfinished expire run continues with another expired entry
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_EXPIRED) && !out_last_result
      |=> out_valid && (out_status == STS_EXPIRED))
    else $error("expire run broken off");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the sorted timer queue: random command traffic against a shadow queue.
module tb_top;
  import stq_pkg::*;

  // Capacity of the block as instantiated: the smaller of the cell count and the handle space.
  localparam int CAP = (DEPTH_DEF < HANDLE_SPACE) ? DEPTH_DEF : HANDLE_SPACE;
  localparam int GAP_MAX = 14;
  localparam int RANDOM_ITEMS = 200;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTED = 30;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One command waiting to go into the block, with the idle cycles that precede it.
  typedef struct {
    op_t                 op;
    logic [TIME_W-1:0]   t_us;
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle;
    int                  gap;
    bit                  hold;
  } cmd_t;

  // One result the block owes us; taken_at marks the edge whose transfer caused it.
  typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag;
    logic [TIME_W-1:0]   deadline;
    logic [TIME_W-1:0]   delay;
    logic                last;
    longint unsigned     taken_at;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_operation = '0;
  logic [TIME_W-1:0]   in_time_us = '0;
  logic [TAG_W-1:0]    in_timer_tag = '0;
  logic [HANDLE_W-1:0] in_timer_handle = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_handle_out;
  logic [TAG_W-1:0]    out_tag_out;
  logic [TIME_W-1:0]   out_deadline_out;
  logic [TIME_W-1:0]   out_delay_us;
  logic                out_last_result;

  sorted_timer_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_time_us       (in_time_us),
    .in_timer_tag     (in_timer_tag),
    .in_timer_handle  (in_timer_handle),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_handle_out   (out_handle_out),
    .out_tag_out      (out_tag_out),
    .out_deadline_out (out_deadline_out),
    .out_delay_us     (out_delay_us),
    .out_last_result  (out_last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cmd_t   cmd_q[$];       // commands not yet offered
  reply_t reply_q[$];     // results owed by the block, oldest first
  entry_t shadow_timers[$];  // pending timers, earliest deadline first
  bit     shadow_used[HANDLE_SPACE];

  int err_count = 0;
  int op_seen[4];
  int status_seen[6];

  // Stimulus shaping state.
  logic [TIME_W-1:0] now_base = '0;
  logic [TIME_W-1:0] last_dl = '0;
  int                calm_left = 0;

  task automatic report_mismatch(string what);
    if (err_count < MAX_PRINTED)
      $display("MISMATCH at %0t: %s", $time, what);
    err_count++;
  endtask

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  // Deadlines cluster just after the current time, repeat often and now and then fly off.
  function automatic logic [TIME_W-1:0] pick_deadline();
    logic [TIME_W-1:0] dl;
    if ($urandom_range(0, 3) == 0)
      dl = last_dl;
    else if ($urandom_range(0, 19) == 0)
      dl = rand48();
    else
      dl = now_base + TIME_W'($urandom_range(0, 300));
    last_dl = dl;
    return dl;
  endfunction

  // Queue one command; gaps come in random lengths, broken by runs of back-to-back transfers.
  function automatic void push_cmd(op_t op, logic [TIME_W-1:0] t_us, logic [TAG_W-1:0] tag,
                                   logic [HANDLE_W-1:0] handle, bit hold);
    cmd_t c;
    c.op = op;
    c.t_us = t_us;
    c.tag = tag;
    c.handle = handle;
    c.hold = hold;
    if (calm_left > 0) begin
      calm_left--;
      c.gap = 0;
    end else if ($urandom_range(0, 7) == 0) begin
      calm_left = $urandom_range(4, 16);
      c.gap = 0;
    end else begin
      c.gap = $urandom_range(0, GAP_MAX);
    end
    cmd_q.push_back(c);
  endfunction

  function automatic reply_t mk_reply(status_t s, logic [HANDLE_W-1:0] h, logic [TAG_W-1:0] tag,
                                      logic [TIME_W-1:0] dl, logic [TIME_W-1:0] dly, logic last);
    reply_t r;
    r.status = s;
    r.handle = h;
    r.tag = tag;
    r.deadline = dl;
    r.delay = dly;
    r.last = last;
    r.taken_at = $time;
    return r;
  endfunction

  // Apply one transferred command to the shadow queue and append the results it owes.
  function automatic void shadow_apply(cmd_t c);
    int     h;
    int     pos;
    int     n_due;
    entry_t e;
    case (c.op)
      OP_ADD: begin
        h = CAP;
        for (int i = CAP - 1; i >= 0; i--)
          if (!shadow_used[i]) h = i;
        if (shadow_timers.size() >= CAP || h == CAP) begin
          reply_q.push_back(mk_reply(STS_FULL, '0, '0, '0, '0, 1'b1));
        end else begin
          // insert ahead of any equal deadline
          pos = 0;
          while (pos < shadow_timers.size() && shadow_timers[pos].deadline < c.t_us) pos++;
          e.deadline = c.t_us;
          e.tag = c.tag;
          e.id = h[HANDLE_W-1:0];
          shadow_timers.insert(pos, e);
          shadow_used[h] = 1'b1;
          reply_q.push_back(mk_reply(STS_OK, h[HANDLE_W-1:0], '0, '0, '0, 1'b1));
        end
      end
      OP_REMOVE: begin
        if (int'(c.handle) >= CAP || !shadow_used[c.handle]) begin
          reply_q.push_back(mk_reply(STS_NOT_FOUND, c.handle, '0, '0, '0, 1'b1));
        end else begin
          pos = 0;
          while (pos < shadow_timers.size() && shadow_timers[pos].id != c.handle) pos++;
          if (pos < shadow_timers.size()) shadow_timers.delete(pos);
          shadow_used[c.handle] = 1'b0;
          reply_q.push_back(mk_reply(STS_OK, c.handle, '0, '0, '0, 1'b1));
        end
      end
      OP_QUERY: begin
        if (shadow_timers.size() == 0)
          reply_q.push_back(mk_reply(STS_EMPTY, '0, '0, '0, '0, 1'b1));
        else if (shadow_timers[0].deadline > c.t_us)
          reply_q.push_back(mk_reply(STS_OK, '0, '0, '0,
                                     shadow_timers[0].deadline - c.t_us, 1'b1));
        else
          reply_q.push_back(mk_reply(STS_OK, '0, '0, '0, '0, 1'b1));
      end
      default: begin
        // the list is sorted, so the due timers are the leading ones
        n_due = 0;
        while (n_due < shadow_timers.size() && n_due < CAP &&
               shadow_timers[n_due].deadline <= c.t_us) n_due++;
        if (n_due == 0)
          reply_q.push_back(mk_reply(STS_NONE_DUE, '0, '0, '0, '0, 1'b1));
        for (int i = 0; i < n_due; i++) begin
          e = shadow_timers.pop_front();
          shadow_used[e.id] = 1'b0;
          reply_q.push_back(mk_reply(STS_EXPIRED, e.id, e.tag, e.deadline, '0,
                                     (i == n_due - 1) ? 1'b1 : 1'b0));
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer commands from cmd_q, one transfer per start/busy handshake.
  // ---------------------------------------------------------------------------
  cmd_t cur;
  int   idle_left = 0;
  bit   stim_done = 1'b0;

  task automatic offer(cmd_t c);
    in_operation    <= c.op;
    in_time_us      <= c.t_us;
    in_timer_tag    <= c.tag;
    in_timer_handle <= c.handle;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        // transfer taken at this edge: advance the shadow queue
        shadow_apply(cur);
        op_seen[int'(cur.op)]++;
        if (cmd_q.size() != 0 && cmd_q[0].gap == 0 && !cmd_q[0].hold) begin
          // keep start high straight into the next command
          cur = cmd_q.pop_front();
          offer(cur);
        end else begin
          start <= 1'b0;
          if (cmd_q.size() == 0) stim_done = 1'b1;
          else idle_left = cmd_q[0].gap;
        end
      end else if (!start && !stim_done) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (cmd_q.size() != 0 && (!cmd_q[0].hold || reply_q.size() == 0)) begin
          // a held command waits until every owed result has come back
          cur = cmd_q.pop_front();
          offer(cur);
          start <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result must match the oldest owed one, field by field.
  // A result owed from a transfer at this very edge cannot be out yet, so treat it
  // as not owed; this keeps the outcome independent of block ordering.
  // ---------------------------------------------------------------------------
  reply_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0 || reply_q[0].taken_at == $time) begin
        report_mismatch($sformatf("result with nothing owed: status %0d handle %0d",
                                  out_status, out_handle_out));
      end else begin
        want = reply_q.pop_front();
        status_seen[int'(want.status)]++;
        if (out_status != want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_handle_out != want.handle)
          report_mismatch($sformatf("handle %0d, want %0d", out_handle_out, want.handle));
        if (out_tag_out != want.tag)
          report_mismatch($sformatf("tag %h, want %h", out_tag_out, want.tag));
        if (out_deadline_out != want.deadline)
          report_mismatch($sformatf("deadline %h, want %h", out_deadline_out, want.deadline));
        if (out_delay_us != want.delay)
          report_mismatch($sformatf("delay %h, want %h", out_delay_us, want.delay));
        if (out_last_result != want.last)
          report_mismatch($sformatf("last flag %0d, want %0d", out_last_result, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int n_directed;
    int kind;
    int r;
    logic [TIME_W-1:0] t_now;

    // Directed: empty queue corners, field extremes, equal deadlines, each operation.
    push_cmd(OP_QUERY,  '0,       '0,           '0,  1'b0);  // query on empty queue
    push_cmd(OP_EXPIRE, '0,       '0,           '0,  1'b0);  // nothing due
    push_cmd(OP_REMOVE, '0,       '0,           4'd0,  1'b0);  // unknown handle, lowest
    push_cmd(OP_REMOVE, TIME_MAX, 32'hFFFF_FFFF, 4'd15, 1'b0);  // unknown handle, highest
    push_cmd(OP_ADD,    '0,       '0,           4'd15, 1'b0);  // earliest possible deadline
    push_cmd(OP_ADD,    TIME_MAX, 32'hFFFF_FFFF, '0,  1'b0);  // latest possible deadline
    push_cmd(OP_ADD,    48'd100,  32'hA5A5_5A5A, '0,  1'b0);
    push_cmd(OP_ADD,    48'd100,  32'h5A5A_A5A5, '0,  1'b0);  // equal deadline goes first
    push_cmd(OP_QUERY,  '0,       '0,           '0,  1'b0);  // head exactly due: delay zero
    push_cmd(OP_EXPIRE, 48'd50,   '0,           '0,  1'b0);  // pops only the zero deadline
    push_cmd(OP_QUERY,  48'd40,   '0,           '0,  1'b0);  // sixty to go
    push_cmd(OP_QUERY,  TIME_MAX, '0,           '0,  1'b0);  // deadline long passed
    push_cmd(OP_REMOVE, '0,       '0,           4'd2,  1'b0);
    push_cmd(OP_REMOVE, '0,       '0,           4'd2,  1'b0);  // same handle again: gone
    push_cmd(OP_ADD,    48'd100,  32'h0000_0001, '0,  1'b0);  // reuses the lowest free handle
    push_cmd(OP_EXPIRE, 48'd99,   '0,           '0,  1'b0);  // one short of due
    push_cmd(OP_EXPIRE, TIME_MAX, '0,           '0,  1'b0);  // flush everything
    n_directed = cmd_q.size();

    // Fill to capacity and one beyond, then flush a full run; hold off until idle first.
    for (int i = 0; i <= CAP; i++)
      push_cmd(OP_ADD, pick_deadline(), $urandom(), 4'($urandom_range(0, 15)), i == 0);
    push_cmd(OP_EXPIRE, TIME_MAX, $urandom(), 4'($urandom_range(0, 15)), 1'b0);

    // Random episodes until the item budget is spent.
    while (cmd_q.size() < n_directed + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
        // burst of adds, often reaching a full queue
        r = $urandom_range(6, CAP + 2);
        for (int i = 0; i < r; i++)
          push_cmd(OP_ADD, pick_deadline(), $urandom(), 4'($urandom_range(0, 15)), 1'b0);
      end else if (kind < 15) begin
        // mixed traffic with time moving forward
        for (int i = 0; i < 12; i++) begin
          r = $urandom_range(0, 99);
          if (r < 35) begin
            push_cmd(OP_ADD, pick_deadline(), $urandom(), 4'($urandom_range(0, 15)),
                     $urandom_range(0, 24) == 0);
          end else if (r < 60) begin
            push_cmd(OP_REMOVE, rand48(), $urandom(),
                     $urandom_range(0, 1) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(0, 15)),
                     $urandom_range(0, 24) == 0);
          end else if (r < 75) begin
            push_cmd(OP_QUERY, now_base + TIME_W'($urandom_range(0, 100)), $urandom(),
                     4'($urandom_range(0, 15)), 1'b0);
          end else begin
            t_now = now_base + TIME_W'($urandom_range(0, 150));
            push_cmd(OP_EXPIRE, t_now, $urandom(), 4'($urandom_range(0, 15)),
                     $urandom_range(0, 24) == 0);
            now_base = t_now;
          end
        end
      end else if (kind < 17) begin
        // flush: expire at the latest time or at a random one, then restart the time line low
        push_cmd(OP_EXPIRE, $urandom_range(0, 1) ? TIME_MAX : rand48(), $urandom(),
                 4'($urandom_range(0, 15)), 1'b0);
        now_base = TIME_W'($urandom_range(0, 5000));
      end else begin
        // noise: every field fully random
        for (int i = 0; i < 4; i++)
          push_cmd(op_t'($urandom_range(0, 3)), rand48(), $urandom(),
                   4'($urandom_range(0, 15)), 1'b0);
      end
    end

    // Hold reset, then release it once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (!stim_done || reply_q.size() != 0) @(posedge clk);
    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d add, %0d remove, %0d query, %0d expire",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("results seen: %0d ok, %0d full, %0d not-found, %0d empty, %0d expired, %0d none-due",
             status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4], status_seen[5]);
    if (err_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("run stalled: %0d results still owed", reply_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
